>>> rtl/core/ecss_pkg.sv
`timescale 1ns / 1ps

package ecss_pkg;

    // Field widths.
    localparam int BitsW  = 4;
    localparam int CountW = 10;
    localparam int SegW   = 8;
    localparam int StepW  = 4;
    localparam int RadixW = 5;
    localparam int DigW   = 16;

    // Configuration port.
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 5;
    localparam logic [CfgIdxW-1:0] REG_STEP_SIZE = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_RADIX     = 1'b1;

    localparam logic [StepW-1:0]  StepReset  = 4'd1;
    localparam logic [RadixW-1:0] RadixReset = 5'd10;
    localparam logic [RadixW-1:0] RadixHex   = 5'd16;

    // Counter range and previous sample after reset.
    localparam logic [CountW:0]  CountWrap   = 11'd1023;
    localparam logic [BitsW-1:0] SampleReset = 4'hF;

    // Serial converter: two bits per cycle over the ten count bits.
    localparam int BitsPerCycle = 2;
    localparam int ConvCycles   = CountW / BitsPerCycle;
    localparam int ConvCntW     = 3;

    localparam logic [SegW-1:0] SegBlank = 8'hFF;

    localparam logic [SegW-1:0] SEG_TABLE [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h98, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
    };

    typedef enum logic {
        ST_IDLE,
        ST_CONV
    } t_state;

    // Status from the digit converter to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_stat;

    // Active-low segment code of one digit.
    function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
        seg_code = SEG_TABLE[digit];
    endfunction

endpackage

>>> rtl/core/ecss_in_if.sv
`timescale 1ns / 1ps

interface ecss_in_if;
    logic                      valid;
    logic                      ready;
    logic [ecss_pkg::BitsW-1:0] encoder_bits;

    modport source (output valid, output encoder_bits, input ready);
    modport sink   (input valid, input encoder_bits, output ready);
endinterface

>>> rtl/core/ecss_out_if.sv
`timescale 1ns / 1ps

interface ecss_out_if;
    logic                       valid;
    logic                       ready;
    logic [ecss_pkg::CountW-1:0] count;
    logic [ecss_pkg::SegW-1:0]   seg_ones;
    logic [ecss_pkg::SegW-1:0]   seg_second;
    logic [ecss_pkg::SegW-1:0]   seg_third;
    logic [ecss_pkg::SegW-1:0]   seg_fourth;

    modport source (output valid, output count, output seg_ones, output seg_second,
                    output seg_third, output seg_fourth, input ready);
    modport sink   (input valid, input count, input seg_ones, input seg_second,
                    input seg_third, input seg_fourth, output ready);
endinterface

>>> rtl/core/ecss_count.sv
`timescale 1ns / 1ps

module ecss_count (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ecss_pkg::BitsW-1:0]  i_bits,
    input  logic [ecss_pkg::StepW-1:0]  i_step,
    output logic [ecss_pkg::CountW-1:0] o_next,
    output logic [ecss_pkg::CountW-1:0] o_count
);

    logic [ecss_pkg::BitsW-1:0]  r_last;
    logic [ecss_pkg::CountW-1:0] r_count;
    logic                        up_a, dn_a, up_b, dn_b, up, dn;
    logic [ecss_pkg::CountW:0]   sum_up;

    // Direction: encoder A wins, encoder B is checked only when A is quiet.
    always_comb begin
        up_a = (r_last[1:0] == 2'b00) && (i_bits[1:0] == 2'b01);
        dn_a = (r_last[1:0] == 2'b01) && (i_bits[1:0] == 2'b00);
        up_b = (r_last[3:2] == 2'b00) && (i_bits[3:2] == 2'b01);
        dn_b = (r_last[3:2] == 2'b01) && (i_bits[3:2] == 2'b00);
        up   = up_a || (!dn_a && up_b);
        dn   = dn_a || (!up_a && dn_b);
    end

    // Next count with wrap by 1023 at both ends.
    always_comb begin
        sum_up = {1'b0, r_count} + {{(ecss_pkg::CountW+1-ecss_pkg::StepW){1'b0}}, i_step};
        if (up) begin
            if (sum_up > ecss_pkg::CountWrap) begin
                sum_up = sum_up - ecss_pkg::CountWrap;
            end
            o_next = sum_up[ecss_pkg::CountW-1:0];
        end else if (dn) begin
            if (r_count >= {{(ecss_pkg::CountW-ecss_pkg::StepW){1'b0}}, i_step}) begin
                o_next = r_count - {{(ecss_pkg::CountW-ecss_pkg::StepW){1'b0}}, i_step};
            end else begin
                o_next = r_count + (ecss_pkg::CountWrap[ecss_pkg::CountW-1:0]
                         - {{(ecss_pkg::CountW-ecss_pkg::StepW){1'b0}}, i_step});
            end
        end else begin
            o_next = r_count;
        end
    end

    // Count and previous sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= ecss_pkg::SampleReset;
            r_count <= '0;
        end else if (i_load) begin
            r_last  <= i_bits;
            r_count <= o_next;
        end
    end

    assign o_count = r_count;

endmodule

>>> rtl/core/ecss_conv.sv
`timescale 1ns / 1ps

module ecss_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_hex,
    input  logic [ecss_pkg::CountW-1:0] i_value,
    input  logic                        i_ack,
    output ecss_pkg::t_conv_stat        o_stat,
    output logic [ecss_pkg::DigW-1:0]   o_digits
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [ecss_pkg::ConvCntW-1:0] r_cnt, n_cnt;
    logic                          r_hex;
    logic [ecss_pkg::CountW-1:0]   r_bin, n_bin;
    logic [ecss_pkg::DigW-1:0]     r_dig, n_dig;

    // Two shift-and-adjust steps per cycle; the adjust is skipped in hex,
    // which leaves plain binary nibbles.
    always_comb begin
        n_dig = r_dig;
        n_bin = r_bin;
        for (int b = 0; b < ecss_pkg::BitsPerCycle; b++) begin
            for (int k = 0; k < ecss_pkg::DigW / 4; k++) begin
                if (!r_hex && (n_dig[k*4 +: 4] >= 4'd5)) begin
                    n_dig[k*4 +: 4] = n_dig[k*4 +: 4] + 4'd3;
                end
            end
            {n_dig, n_bin} = {n_dig[ecss_pkg::DigW-2:0], n_bin, 1'b0};
        end
    end

    // Step counter and handshake to the sequencer.
    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == ecss_pkg::ConvCntW'(ecss_pkg::ConvCycles - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_ack) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Shift registers for the binary value and the digits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hex <= i_hex;
            r_bin <= i_value;
            r_dig <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_dig <= n_dig;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_digits    = r_dig;

endmodule

>>> rtl/core/encoder_counter_seven_segment.sv
`timescale 1ns / 1ps

// Rotary encoder counter with a four-digit seven-segment readout. Each input
// word is one sample of two quadrature encoders; a 00->01 or 01->00 change on
// encoder A (or on encoder B when A shows neither) moves the count, which
// stays in 0..1023, by step_size. Each sample gives one output word with the
// count and four active-low digit codes in base 10 or 16 (radix 16 selects
// hex), leading zero digits blanked to 0xFF. Once a sample is accepted, the
// count is updated at the accepting edge, the digit converter then shifts
// two count bits per cycle through all ten count bits, the output register
// is loaded once it is free, and the sequencer returns to the idle state,
// where the input is ready again. A finished word waits in the output
// register while the next sample is taken in; a word still held there stalls
// the following one.
module encoder_counter_seven_segment (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ecss_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [ecss_pkg::CfgDataW-1:0] i_cfg_data,
    ecss_in_if.sink                      i_in,
    ecss_out_if.source                   o_out
);

    ecss_pkg::t_state            r_state, n_state;
    ecss_pkg::t_conv_stat        conv_stat;
    logic [ecss_pkg::StepW-1:0]  r_step;
    logic [ecss_pkg::RadixW-1:0] r_radix;
    logic [ecss_pkg::CountW-1:0] next_count, count;
    logic [ecss_pkg::DigW-1:0]   digits;
    logic                        accept, load_out, out_free;
    logic                        r_out_valid;
    logic [ecss_pkg::CountW-1:0] r_out_count;
    logic [ecss_pkg::SegW-1:0]   r_seg0, r_seg1, r_seg2, r_seg3;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ecss_pkg::StepReset;
            r_radix <= ecss_pkg::RadixReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecss_pkg::REG_STEP_SIZE: r_step  <= i_cfg_data[ecss_pkg::StepW-1:0];
                ecss_pkg::REG_RADIX:     r_radix <= i_cfg_data[ecss_pkg::RadixW-1:0];
                default: ;
            endcase
        end
    end

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    ecss_count u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_bits  (i_in.encoder_bits),
        .i_step  (r_step),
        .o_next  (next_count),
        .o_count (count)
    );

    ecss_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_hex    (r_radix == ecss_pkg::RadixHex),
        .i_value  (next_count),
        .i_ack    (load_out),
        .o_stat   (conv_stat),
        .o_digits (digits)
    );

    // Sequencer: one sample in flight until its word reaches the output register.
    // The input is held off while reset is asserted.
    always_comb begin
        n_state    = r_state;
        load_out   = 1'b0;
        i_in.ready = 1'b0;
        case (r_state)
            ecss_pkg::ST_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid) begin
                    n_state = ecss_pkg::ST_CONV;
                end
            end
            ecss_pkg::ST_CONV: begin
                if (conv_stat.done && !conv_stat.busy && out_free) begin
                    load_out = 1'b1;
                    n_state  = ecss_pkg::ST_IDLE;
                end
            end
            default: n_state = ecss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecss_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word: segment codes with leading zero digits blanked.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_count <= count;
            r_seg0      <= ecss_pkg::seg_code(digits[3:0]);
            r_seg1      <= (digits[15:4] == '0) ? ecss_pkg::SegBlank
                                                : ecss_pkg::seg_code(digits[7:4]);
            r_seg2      <= (digits[15:8] == '0) ? ecss_pkg::SegBlank
                                                : ecss_pkg::seg_code(digits[11:8]);
            r_seg3      <= (digits[15:12] == '0) ? ecss_pkg::SegBlank
                                                 : ecss_pkg::seg_code(digits[15:12]);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.count      = r_out_count;
    assign o_out.seg_ones   = r_seg0;
    assign o_out.seg_second = r_seg1;
    assign o_out.seg_third  = r_seg2;
    assign o_out.seg_fourth = r_seg3;

endmodule

>>> tb/sv/encoder_counter_seven_segment_tb.sv
`timescale 1ns / 1ps

module encoder_counter_seven_segment_tb;
    import ecss_pkg::*;

    localparam int COUNT_SPAN   = 1023;
    localparam int RADIX_DEC    = 10;
    localparam int ANY_STEP     = -1;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    // Active-low digit glyphs, 0 through F.
    localparam logic [SegW-1:0] GLYPH [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h98, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
    };

    // Quadrature order of one encoder pair; stepping forward gives 00 -> 01.
    localparam logic [1:0] GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    // Opening samples: idle lines, underflow below zero, overflow past 1023,
    // both encoders moving at once (A wins), A up while B goes down, and B
    // counting while A changes without a transition.
    localparam logic [BitsW-1:0] OPENING [20] = '{
        4'hF, 4'h0, 4'h3, 4'h1, 4'h0, 4'h1, 4'h3, 4'h2, 4'h0, 4'h1,
        4'h0, 4'h5, 4'h4, 4'h1, 4'h0, 4'h4, 4'h0, 4'h3, 4'h6, 4'hF
    };

    // Settings per phase; radix values other than 16 select decimal.
    localparam int PHASE_STEP  [PHASES] = '{15, 0, 15, 1, ANY_STEP, 8, 15, ANY_STEP};
    localparam int PHASE_RADIX [PHASES] = '{16, 31, 10, 0, 16, 17, 10, 16};
    localparam int PHASE_ITEMS [PHASES] = '{250, 60, 250, 100, 150, 100, 200, 150};

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [SegW-1:0]   ones;
        logic [SegW-1:0]   second;
        logic [SegW-1:0]   third;
        logic [SegW-1:0]   fourth;
    } t_readout;

    // Tracks the counter and display, and checks each output word in order.
    class readout_scoreboard;
        logic [BitsW-1:0]  prev_bits;
        logic [CountW-1:0] count;
        logic [StepW-1:0]  step;
        logic [RadixW-1:0] radix;
        t_readout          readouts_due[$];
        int                errors;

        function new();
            prev_bits = SampleReset;
            count     = '0;
            step      = StepReset;
            radix     = RadixReset;
            errors    = 0;
        endfunction

        function void write_reg(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
            if (idx == REG_STEP_SIZE) begin
                step = data[StepW-1:0];
            end else if (idx == REG_RADIX) begin
                radix = data[RadixW-1:0];
            end
        endfunction

        function int pair_move(input logic [1:0] was, input logic [1:0] now);
            if (was == 2'b00 && now == 2'b01) return 1;
            if (was == 2'b01 && now == 2'b00) return -1;
            return 0;
        endfunction

        // Advances the count for one accepted sample and queues the readout.
        function void predict_sample(input logic [BitsW-1:0] bits);
            int               dir;
            int               next_val;
            int unsigned      base;
            int unsigned      v;
            int unsigned      ndig;
            logic [SegW-1:0]  segs [4];
            t_readout         want;

            dir = pair_move(prev_bits[1:0], bits[1:0]);
            if (dir == 0) dir = pair_move(prev_bits[3:2], bits[3:2]);
            prev_bits = bits;

            next_val = int'(count) + dir * int'(step);
            if (next_val > COUNT_SPAN) begin
                next_val -= COUNT_SPAN;
            end else if (next_val < 0) begin
                next_val += COUNT_SPAN;
            end
            count = next_val[CountW-1:0];

            base = (radix == RadixHex) ? 16 : RADIX_DEC;
            ndig = 1;
            v    = count;
            while (ndig < 4 && v >= base) begin
                v /= base;
                ndig++;
            end
            v = count;
            for (int k = 0; k < 4; k++) begin
                segs[k] = (k < ndig) ? GLYPH[v % base] : SegBlank;
                v /= base;
            end

            want = '{count: count, ones: segs[0], second: segs[1],
                     third: segs[2], fourth: segs[3]};
            readouts_due.push_back(want);
        endfunction

        function void compare_readout(input t_readout got);
            t_readout want;
            if (readouts_due.size() == 0) begin
                $error("unexpected output word: count %0d", got.count);
                errors++;
                return;
            end
            want = readouts_due.pop_front();
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.ones !== want.ones) begin
                $error("seg_ones: expected %h, got %h", want.ones, got.ones);
                errors++;
            end
            if (got.second !== want.second) begin
                $error("seg_second: expected %h, got %h", want.second, got.second);
                errors++;
            end
            if (got.third !== want.third) begin
                $error("seg_third: expected %h, got %h", want.third, got.third);
                errors++;
            end
            if (got.fourth !== want.fourth) begin
                $error("seg_fourth: expected %h, got %h", want.fourth, got.fourth);
                errors++;
            end
        endfunction

        function int pending();
            return readouts_due.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    ecss_in_if  in_if ();
    ecss_out_if out_if ();

    encoder_counter_seven_segment i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    readout_scoreboard board = new();

    logic [BitsW-1:0] last_sent = SampleReset;
    int               sent_total = 0;
    bit               tx_idle = 1'b1;
    bit               rx_idle = 1'b1;
    bit               hold_request = 1'b0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("encoder_counter_seven_segment_tb: errors");
        $finish;
    end

    // Output side: checks each word taken and stalls in random bursts, or for
    // one long stretch on request so that the block backs up.
    initial begin : readout_sink
        int       stall_left;
        t_readout got;
        stall_left = 0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got = '{count: out_if.count, ones: out_if.seg_ones,
                        second: out_if.seg_second, third: out_if.seg_third,
                        fourth: out_if.seg_fourth};
                board.compare_readout(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && rx_idle && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Offers one sample word, with an optional gap first, and waits for it
    // to be taken.
    task automatic send_word(input logic [BitsW-1:0] bits);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.encoder_bits <= bits;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.predict_sample(bits);
        last_sent = bits;
        sent_total++;
    endtask

    // Stops offering and waits until every expected word has come back.
    task automatic drain_readouts();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic load_settings(input int step, input int radix);
        drain_readouts();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_STEP_SIZE;
        i_cfg_data <= CfgDataW'(step);
        @(posedge i_clk);
        board.write_reg(REG_STEP_SIZE, CfgDataW'(step));
        i_cfg_idx  <= REG_RADIX;
        i_cfg_data <= CfgDataW'(radix);
        @(posedge i_clk);
        board.write_reg(REG_RADIX, CfgDataW'(radix));
        i_cfg_we <= 1'b0;
    endtask

    // Turns one encoder by a given number of quadrature steps. The other encoder is
    // held when B turns, and jitters at random when A turns.
    task automatic spin_encoder(input bit on_b, input bit up, input int turns);
        int               pos;
        logic [1:0]       pair;
        logic [BitsW-1:0] bits;
        pair = on_b ? last_sent[3:2] : last_sent[1:0];
        pos  = 0;
        for (int k = 0; k < 4; k++) begin
            if (GRAY[k] == pair) pos = k;
        end
        repeat (turns) begin
            pos = up ? (pos + 1) % 4 : (pos + 3) % 4;
            if (on_b) begin
                bits = {GRAY[pos], last_sent[1:0]};
            end else begin
                bits      = {2'b00, GRAY[pos]};
                bits[3:2] = 2'($urandom_range(0, 3));
            end
            send_word(bits);
        end
    endtask

    // One stretch of random stimulus: mostly clean rotation, some line noise
    // and some dithering on a single line.
    task automatic random_stretch();
        int               pick;
        logic [BitsW-1:0] flip;
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            spin_encoder($urandom_range(0, 2) == 0, $urandom_range(0, 1),
                         $urandom_range(1, 40));
        end else if (pick <= 8) begin
            repeat ($urandom_range(1, 8)) send_word(BitsW'($urandom_range(0, 15)));
        end else begin
            flip = ($urandom_range(0, 1) == 0) ? 4'b0001 : 4'b0100;
            repeat ($urandom_range(2, 10)) send_word(last_sent ^ flip);
        end
    endtask

    // Main sequence.
    initial begin : stimulus
        int step;
        int goal;
        int midpoint;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= REG_STEP_SIZE;
        i_cfg_data         <= '0;
        in_if.valid        <= 1'b0;
        in_if.encoder_bits <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening samples run at the reset settings.
        foreach (OPENING[k]) send_word(OPENING[k]);

        for (int ph = 0; ph < PHASES; ph++) begin
            step = (PHASE_STEP[ph] == ANY_STEP) ? $urandom_range(2, 14) : PHASE_STEP[ph];
            load_settings(step, PHASE_RADIX[ph]);
            tx_idle  = (ph != PHASES - 1) && (ph != 1);
            rx_idle  = (ph != PHASES - 1) && (ph != 3);
            goal     = sent_total + PHASE_ITEMS[ph];
            midpoint = sent_total + PHASE_ITEMS[ph] / 2;
            while (sent_total < goal) begin
                if (midpoint > 0 && sent_total >= midpoint) begin
                    midpoint = 0;
                    if (ph == 2) hold_request = 1'b1;
                    if (ph == 4) drain_readouts();
                end
                random_stretch();
            end
        end

        drain_readouts();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("encoder_counter_seven_segment_tb: clean");
        end else begin
            $display("encoder_counter_seven_segment_tb: errors");
        end
        $finish;
    end

endmodule

>>> encoder_counter_seven_segment.f
rtl/core/ecss_pkg.sv
rtl/core/ecss_in_if.sv
rtl/core/ecss_out_if.sv
rtl/core/ecss_count.sv
rtl/core/ecss_conv.sv
rtl/core/encoder_counter_seven_segment.sv
tb/sv/encoder_counter_seven_segment_tb.sv
